/* src/spcl_pkg.sv */
// Shared types and constants for the serial password checker with lockout.
// No dependencies; every other file refers to this package by scoped names.
package spcl_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_PW_LOW  = 2'd0;
   localparam csr_idx_type CSR_PW_HIGH = 2'd1;
   localparam csr_idx_type CSR_LIMIT   = 2'd2;

   localparam int CSR_DATA_W = 64;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Field types
   typedef logic [7:0] byte_type;
   typedef logic [2:0] status_type;
   typedef logic [2:0] count3_type;
   typedef logic [3:0] typed_type;

   // Result status codes
   localparam status_type ST_TAKEN   = 3'd0;
   localparam status_type ST_DROPPED = 3'd1;
   localparam status_type ST_EMPTY   = 3'd2;
   localparam status_type ST_DENIED  = 3'd3;
   localparam status_type ST_GRANTED = 3'd4;
   localparam status_type ST_LOCKED  = 3'd5;
   localparam status_type ST_IGNORED = 3'd6;

   // Line end characters
   localparam byte_type BYTE_CR = 8'd13;
   localparam byte_type BYTE_LF = 8'd10;

   localparam count3_type FAIL_MAX    = 3'd7;
   localparam count3_type LIMIT_RESET = 3'd3;

endpackage

/* src/spcl_req_if.sv */
// Input channel: one received console byte per item.
// Depends on spcl_pkg.
interface spcl_req_if;
   logic               valid;
   logic               ready;
   spcl_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/spcl_rsp_if.sv */
// Result channel: status and failure count per item.
// Depends on spcl_pkg.
interface spcl_rsp_if;
   logic                 valid;
   logic                 ready;
   spcl_pkg::status_type status;
   spcl_pkg::count3_type failures_so_far;

   modport source (output valid, output status, output failures_so_far, input ready);
   modport sink   (input valid, input status, input failures_so_far, output ready);
endinterface

/* src/spcl_csr_if.sv */
// Configuration write channel: register index and write data.
// Depends on spcl_pkg.
interface spcl_csr_if;
   logic                   valid;
   logic                   ready;
   spcl_pkg::csr_idx_type  reg_index;
   spcl_pkg::csr_data_type wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* src/serial_password_checker_lockout_unit.sv */
// Top level of the serial password checker with lockout.
// Depends on spcl_pkg, the three channel interfaces, spcl_csr and spcl_core.
//
//   channel   direction  item contents
//   req_chan  in         rx_byte
//   rsp_chan  out        status, failures_so_far
//   csr_chan  in         reg_index, wr_data (always ready)
//
// One result per byte via the input register; one byte per cycle while rsp_chan.ready holds.
// Session state (line position, mismatch, failures, phase) loads with the result register.
// Reset is synchronous, clears valid and session state; password reads as zero, limit as 3.
// A stalled result holds in the output register while the input register still takes
// a byte; backpressure reaches req_chan.ready once both registers are full.
module serial_password_checker_lockout_unit #(
   parameter int PASSWORD_BYTES = 16
) (
   input logic        clock,
   input logic        reset,
   spcl_req_if.sink   req_chan,
   spcl_rsp_if.source rsp_chan,
   spcl_csr_if.sink   csr_chan
);

   logic [PASSWORD_BYTES*8-1:0] pw_bytes;
   spcl_pkg::count3_type        attempt_limit;

   assign csr_chan.ready = 1'b1;

   // Configuration registers
   spcl_csr #(
      .PASSWORD_BYTES (PASSWORD_BYTES)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .wr_valid      (csr_chan.valid),
      .wr_index      (csr_chan.reg_index),
      .wr_data       (csr_chan.wr_data),
      .pw_bytes      (pw_bytes),
      .attempt_limit (attempt_limit)
   );

   // Checker datapath
   spcl_core #(
      .PASSWORD_BYTES (PASSWORD_BYTES)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .pw_bytes      (pw_bytes),
      .attempt_limit (attempt_limit),
      .in_valid      (req_chan.valid),
      .in_byte       (req_chan.rx_byte),
      .in_ready      (req_chan.ready),
      .out_valid     (rsp_chan.valid),
      .out_status    (rsp_chan.status),
      .out_failures  (rsp_chan.failures_so_far),
      .out_ready     (rsp_chan.ready)
   );

endmodule

/* src/spcl_csr.sv */
// Configuration registers: stored password bytes and the attempt limit.
// Depends on spcl_pkg.
module spcl_csr #(
   parameter int PASSWORD_BYTES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_valid,
   input  spcl_pkg::csr_idx_type          wr_index,
   input  spcl_pkg::csr_data_type         wr_data,
   output logic [PASSWORD_BYTES*8-1:0]    pw_bytes,
   output spcl_pkg::count3_type           attempt_limit
);

   logic [PASSWORD_BYTES*8-1:0] pw_ff;
   spcl_pkg::count3_type        limit_ff;

   // Password bytes: the first eight come from the low word, the rest from the high word
   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff <= '0;
      end else if (wr_valid) begin
         for (int b = 0; b < PASSWORD_BYTES; b++) begin
            if (b < 8 && wr_index == spcl_pkg::CSR_PW_LOW) begin
               pw_ff[b*8 +: 8] <= wr_data[(b % 8)*8 +: 8];
            end else if (b >= 8 && wr_index == spcl_pkg::CSR_PW_HIGH) begin
               pw_ff[b*8 +: 8] <= wr_data[(b % 8)*8 +: 8];
            end
         end
      end
   end

   // Attempt limit
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= spcl_pkg::LIMIT_RESET;
      end else if (wr_valid && wr_index == spcl_pkg::CSR_LIMIT) begin
         limit_ff <= wr_data[2:0];
      end
   end

   assign pw_bytes      = pw_ff;
   assign attempt_limit = limit_ff;

endmodule

/* src/spcl_core.sv */
// Checker datapath: input register, line compare and lockout logic, result register.
// Depends on spcl_pkg.
module spcl_core #(
   parameter int PASSWORD_BYTES = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [PASSWORD_BYTES*8-1:0] pw_bytes,
   input  spcl_pkg::count3_type        attempt_limit,
   input  logic                        in_valid,
   input  spcl_pkg::byte_type          in_byte,
   output logic                        in_ready,
   output logic                        out_valid,
   output spcl_pkg::status_type        out_status,
   output spcl_pkg::count3_type        out_failures,
   input  logic                        out_ready
);

   localparam int IDX_W = $clog2(PASSWORD_BYTES);

   // Session phase codes
   localparam logic [1:0] PH_ACTIVE  = 2'd0;
   localparam logic [1:0] PH_GRANTED = 2'd1;
   localparam logic [1:0] PH_LOCKED  = 2'd2;

   // Input stage
   logic               s1_valid_ff;
   spcl_pkg::byte_type s1_byte_ff;

   // Session state
   spcl_pkg::typed_type  typed_ff, typed_in;
   logic                 mis_ff, mis_in;
   logic                 term_ff, term_in;
   spcl_pkg::count3_type fail_ff, fail_in;
   logic [1:0]           phase_ff, phase_in;

   // Result stage
   logic                 rsp_valid_ff;
   spcl_pkg::status_type status_ff, status_in;
   spcl_pkg::count3_type rsp_fail_ff;

   logic                 advance;
   logic                 fire;
   spcl_pkg::byte_type   pw_arr [PASSWORD_BYTES];
   spcl_pkg::byte_type   stored;
   spcl_pkg::count3_type fail_inc;
   logic                 line_match;

   assign advance  = !rsp_valid_ff || out_ready;
   assign fire     = s1_valid_ff && advance;
   assign in_ready = !s1_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (in_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_byte_ff <= in_byte;
      end
   end

   // Stored byte at the current position; positions past the store read as zero
   always_comb begin
      for (int i = 0; i < PASSWORD_BYTES; i++) begin
         pw_arr[i] = pw_bytes[i*8 +: 8];
      end
   end

   assign stored = (32'(typed_ff) < PASSWORD_BYTES) ? pw_arr[typed_ff[IDX_W-1:0]] : 8'd0;
   assign fail_inc   = (fail_ff < spcl_pkg::FAIL_MAX) ? fail_ff + 3'd1 : fail_ff;
   assign line_match = !mis_ff && (term_ff || stored == 8'd0);

   // Per-item decision and next state
   always_comb begin
      typed_in  = typed_ff;
      mis_in    = mis_ff;
      term_in   = term_ff;
      fail_in   = fail_ff;
      phase_in  = phase_ff;
      status_in = spcl_pkg::ST_IGNORED;
      if (phase_ff != PH_ACTIVE) begin
         status_in = spcl_pkg::ST_IGNORED;
      end else if (s1_byte_ff inside {spcl_pkg::BYTE_CR, spcl_pkg::BYTE_LF}) begin
         if (typed_ff == 4'd0) begin
            status_in = spcl_pkg::ST_EMPTY;
         end else if (line_match) begin
            status_in = spcl_pkg::ST_GRANTED;
            phase_in  = PH_GRANTED;
         end else begin
            fail_in = fail_inc;
            if (fail_inc >= attempt_limit) begin
               status_in = spcl_pkg::ST_LOCKED;
               phase_in  = PH_LOCKED;
            end else begin
               status_in = spcl_pkg::ST_DENIED;
            end
            typed_in = 4'd0;
            mis_in   = 1'b0;
            term_in  = 1'b0;
         end
      end else if (32'(typed_ff) < PASSWORD_BYTES - 1) begin
         if (!term_ff) begin
            if (s1_byte_ff != stored) begin
               mis_in = 1'b1;
            end
            if (s1_byte_ff == 8'd0) begin
               term_in = 1'b1;
            end
         end
         typed_in  = typed_ff + 4'd1;
         status_in = spcl_pkg::ST_TAKEN;
      end else begin
         status_in = spcl_pkg::ST_DROPPED;
      end
   end

   // Session state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         typed_ff <= 4'd0;
         mis_ff   <= 1'b0;
         term_ff  <= 1'b0;
         fail_ff  <= 3'd0;
         phase_ff <= PH_ACTIVE;
      end else if (fire) begin
         typed_ff <= typed_in;
         mis_ff   <= mis_in;
         term_ff  <= term_in;
         fail_ff  <= fail_in;
         phase_ff <= phase_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff   <= status_in;
         rsp_fail_ff <= fail_in;
      end
   end

   assign out_valid    = rsp_valid_ff;
   assign out_status   = status_ff;
   assign out_failures = rsp_fail_ff;

   // Grant and lockout are final until reset
   a_phase_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_ACTIVE |=> phase_ff == $past(phase_ff))
      else $error("session phase left grant or lockout");

   // Failure count only grows within a session
   a_fail_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> fail_ff >= $past(fail_ff))
      else $error("failure count decreased");

   // A line never holds more than the compare window
   a_typed_bound: assert property (@(posedge clock) disable iff (reset)
      32'(typed_ff) <= PASSWORD_BYTES - 1)
      else $error("typed count past line limit");

   // A terminating zero byte is counted as a typed character
   a_term_counted: assert property (@(posedge clock) disable iff (reset)
      term_ff |-> typed_ff != 4'd0)
      else $error("terminated text with no typed characters");

   // A shown grant matches the recorded session phase
   a_grant_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == spcl_pkg::ST_GRANTED |-> phase_ff == PH_GRANTED)
      else $error("grant reported without granted phase");

endmodule
